[rtl/assert_macros.svh]
// Assertion macros used by the RTL file sem_queue.sv; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sem_pkg.sv]
// Shared types, constants and the helper function of the Sobel edge magnitude block.
package sem_pkg;

  localparam int PIX_W   = 8;
  localparam int FW_W    = 12;
  localparam int FH_W    = 13;
  localparam int CFG_W   = 13;
  localparam int OCOL_W  = 11;
  localparam int OROW_W  = 12;
  localparam int GRAD_W  = 11;
  localparam int SUM_W   = 21;
  localparam int ROOT_W  = 16;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // Position and frame mark of an interior pixel.
  typedef struct packed {
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              fend;
  } sem_meta_t;

  // One pixel with its freshly read column of the 3x3 window.
  typedef struct packed {
    logic [PIX_W-1:0] a0;
    logic [PIX_W-1:0] a1;
    logic [PIX_W-1:0] px;
    logic             emit;
    sem_meta_t        meta;
  } sem_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] res;
  } sem_sqrt_t;

  // One digit of the bitwise integer square root.
  function automatic sem_sqrt_t sem_sqrt_step(input sem_sqrt_t s, input logic [ROOT_W-1:0] b);
    sem_sqrt_t    o;
    logic [ROOT_W:0] trial;
    trial = {1'b0, s.res} + {1'b0, b};
    if ({1'b0, s.rem} >= trial) begin
      o.rem = s.rem - trial[ROOT_W-1:0];
      o.res = (s.res >> 1) + b;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

[rtl/sem_front.sv]
// Front end: pixel counters, interior classification and the line store of the two rows above.
module sem_front #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sem_pkg::FW_W-1:0]  frame_width,
  input  logic [sem_pkg::FH_W-1:0]  frame_height,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sem_pkg::PIX_W-1:0] in_red_sample,
  input  logic                      q_full,
  output logic                      q_push,
  output sem_pkg::sem_item_t        q_item
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  logic             f1_valid_r;
  logic [PIX_W-1:0] f1_px_r;
  logic [CW-1:0]    f1_addr_r;
  logic             f1_emit_r;
  sem_meta_t        f1_meta_r;

  // Each entry holds the row two above in the upper byte and the row above in the lower.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;

  logic      accept;
  logic      emit;
  sem_meta_t meta;

  // The frame size is applied to the very next request after a register write.
  always_comb begin
    int w;
    int h;
    w = int'(frame_width);
    h = int'(frame_height);
    if (w < 3) w = 3;
    else if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    else if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    last_col = CW'(w - 1);
    last_row = RW'(h - 1);
  end

  assign q_push   = f1_valid_r && !q_full;
  assign in_ready = !f1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  assign emit = (col_r >= CW'(2)) && (col_r <= last_col) &&
                (row_r >= RW'(2)) && (row_r <= last_row);
  assign meta.col  = OCOL_W'(col_r - 1'b1);
  assign meta.row  = OROW_W'(row_r - 1'b1);
  assign meta.fend = (col_r == last_col) && (row_r == last_row);

  assign q_item.a0   = rd_r[2*PIX_W-1:PIX_W];
  assign q_item.a1   = rd_r[PIX_W-1:0];
  assign q_item.px   = f1_px_r;
  assign q_item.emit = f1_emit_r;
  assign q_item.meta = f1_meta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        f1_valid_r <= 1'b1;
        if (col_r >= last_col) begin
          col_r <= '0;
          row_r <= (row_r >= last_row) ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end else if (q_push) begin
        f1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px_r   <= in_red_sample;
      f1_addr_r <= col_r;
      f1_emit_r <= emit;
      f1_meta_r <= meta;
    end
  end

  // Read for the incoming pixel and write back for the previous one; the addresses
  // always differ because a row is at least three pixels wide.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_r];
    end
    if (q_push) begin
      line_mem[f1_addr_r] <= {rd_r[PIX_W-1:0], f1_px_r};
    end
  end

endmodule

[rtl/sem_queue.sv]
// Short queue between the front end and the arithmetic back end.
`include "assert_macros.svh"

module sem_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sem_pkg::sem_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output sem_pkg::sem_item_t head_item
);
  import sem_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sem_item_t        slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_IMPLIES(a_q_bound, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `ASSERT_IMPLIES(a_q_no_underrun, pop, cnt_r != '0, "pop from an empty queue")
  `ASSERT_NEXT(a_q_fill, push && !pop, cnt_r == CNT_W'($past(cnt_r) + 1'b1), "count missed a push")
  `ASSERT_NEXT(a_q_idle, cnt_r == '0 && !push, cnt_r == '0, "empty queue filled by itself")

endmodule

[rtl/sem_back.sv]
// Back end: window columns, Sobel gradients, squared sum, square root and output register.
module sem_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  sem_pkg::sem_item_t        q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sem_pkg::PIX_W-1:0] out_edge_magnitude,
  output logic [sem_pkg::OCOL_W-1:0] out_col,
  output logic [sem_pkg::OROW_W-1:0] out_row,
  output logic                      out_frame_end
);
  import sem_pkg::*;

  localparam int HALF_STEPS = 4;

  logic adv;

  // Index 0 is the top row of the window, index 2 the incoming row.
  logic [2:0][PIX_W-1:0] win_l_r;
  logic [2:0][PIX_W-1:0] win_m_r;
  logic [2:0][PIX_W-1:0] win_r;

  logic signed [GRAD_W-1:0] gx_nxt, gy_nxt, gx_r, gy_r;
  logic                     v1_r, v2_r, v3_r;
  sem_meta_t                m1_r, m2_r, m3_r;

  logic [SUM_W-1:0]  sum_nxt, sum_r;
  sem_sqrt_t         sq_a_nxt, sq_a_r, sq_b_nxt;
  logic              sat_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_mag_r;
  sem_meta_t         out_meta_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = q_valid && adv;
  assign win_r = {q_item.px, q_item.a1, q_item.a0};

  always_comb begin
    logic [PIX_W+1:0] left, right, top, bottom;
    right  = {2'b0, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b0, win_r[2]};
    left   = {2'b0, win_l_r[0]} + {1'b0, win_l_r[1], 1'b0} + {2'b0, win_l_r[2]};
    bottom = {2'b0, win_l_r[2]} + {1'b0, win_m_r[2], 1'b0} + {2'b0, win_r[2]};
    top    = {2'b0, win_l_r[0]} + {1'b0, win_m_r[0], 1'b0} + {2'b0, win_r[0]};
    gx_nxt = $signed({1'b0, right}) - $signed({1'b0, left});
    gy_nxt = $signed({1'b0, bottom}) - $signed({1'b0, top});
  end

  always_comb begin
    logic signed [2*GRAD_W-1:0] px2, py2;
    px2     = gx_r * gx_r;
    py2     = gy_r * gy_r;
    sum_nxt = SUM_W'(px2) + SUM_W'(py2);
  end

  // The root is split into two halves of four digits each.
  always_comb begin
    sq_a_nxt.rem = sum_r[ROOT_W-1:0];
    sq_a_nxt.res = '0;
    for (int k = 0; k < HALF_STEPS; k++) begin
      sq_a_nxt = sem_sqrt_step(sq_a_nxt, ROOT_W'(1) << (ROOT_W - 2 - 2 * k));
    end
    sq_b_nxt = sq_a_r;
    for (int k = HALF_STEPS; k < 2 * HALF_STEPS; k++) begin
      sq_b_nxt = sem_sqrt_step(sq_b_nxt, ROOT_W'(1) << (ROOT_W - 2 - 2 * k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r     <= '0;
      win_m_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (q_pop) begin
        win_l_r <= win_m_r;
        win_m_r <= win_r;
      end
      v1_r        <= q_pop && q_item.emit;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r       <= gx_nxt;
      gy_r       <= gy_nxt;
      m1_r       <= q_item.meta;
      sum_r      <= sum_nxt;
      m2_r       <= m1_r;
      sq_a_r     <= sq_a_nxt;
      sat_r      <= |sum_r[SUM_W-1:ROOT_W];
      m3_r       <= m2_r;
      out_mag_r  <= sat_r ? {PIX_W{1'b1}} : sq_b_nxt.res[PIX_W-1:0];
      out_meta_r <= m3_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_edge_magnitude = out_mag_r;
  assign out_col            = out_meta_r.col;
  assign out_row            = out_meta_r.row;
  assign out_frame_end      = out_meta_r.fend;

endmodule

[rtl/sobel_edge_magnitude.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Pixels enter on the in_ channel (valid/ready), one red sample per request, in
// raster order. For every interior pixel one request leaves on the out_ channel
// with the saturated gradient magnitude, its column, its row and an end-of-frame
// mark; border pixels produce nothing. The result of interior pixel (x, y) is
// produced by the request of pixel (x+1, y+1). Throughput is one pixel per cycle
// while the receiver does not stall, set by one line store read and one write-back
// per cycle in the front end and a fully pipelined back end. A four-entry queue
// separates the front end from the arithmetic pipeline; when the receiver stalls,
// the back end holds and the queue fills, then in_ready drops. Frame width and
// height must be written through cfg_ only while the block is idle; the block does
// not enforce this. They are used clamped to at least 3 and at most MAX_WIDTH /
// MAX_HEIGHT. Reset clears the counters, window and queue and restores a 640 x 480
// frame; the line store needs no clearing: only border pixels read unwritten data.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sem_pkg::PIX_W-1:0]  in_red_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sem_pkg::PIX_W-1:0]  out_edge_magnitude,
  output logic [sem_pkg::OCOL_W-1:0] out_col,
  output logic [sem_pkg::OROW_W-1:0] out_row,
  output logic                       out_frame_end
);
  import sem_pkg::*;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  sem_item_t push_item;
  sem_item_t head_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_sample (in_red_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  sem_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  sem_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (head_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_edge_magnitude (out_edge_magnitude),
    .out_col            (out_col),
    .out_row            (out_row),
    .out_frame_end      (out_frame_end)
  );

endmodule
